// File: rtl/core/trs_pkg.sv
// Shared constants, codes and types for the thermistor reading smoother.
package trs_pkg;

  // Field widths fixed by the stream format.
  localparam int READ_W  = 16;  // raw reading, signed centidegrees
  localparam int DATA_W  = 14;  // stored window entry
  localparam int TRK_W   = 15;  // tracked value, signed centidegrees
  localparam int LIMIT_W = 3;   // error limit and reject counters
  localparam int CFG_W   = 14;  // widest configuration register

  // Quotient bits of the rounding divide; the rounded mean stays below 512 steps.
  localparam int QUOT_W = 9;

  localparam int DEF_WINDOW_DEPTH = 8;

  localparam logic [LIMIT_W-1:0] DEF_ERROR_LIMIT = 3'd5;
  localparam logic [CFG_W-1:0]   DEF_MAX_TEMP    = 14'd6000;
  localparam logic [LIMIT_W-1:0] REJECT_MAX      = 3'd7;

  // Offset bands in centidegrees.
  localparam int BAND_LOW    = 1900;
  localparam int BAND_HIGH   = 2300;
  localparam int OFFSET_LOW  = 130;
  localparam int OFFSET_MID  = 160;
  localparam int OFFSET_HIGH = 180;

  // Rounding grid of the tracked value.
  localparam int STEP_CENTI = 50;

  typedef enum logic {
    REG_ERROR_LIMIT    = 1'b0,
    REG_MAX_VALID_TEMP = 1'b1
  } reg_idx_t;

  // Status of the iterative divider as seen by the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } trs_div_stat_t;

endpackage

// File: rtl/core/trs_divider.sv
// Iterative restoring divider, one quotient bit per cycle.
module trs_divider import trs_pkg::*; #(
  parameter int W  = 24,
  parameter int QW = QUOT_W
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [W-1:0]  dividend,
  input  logic [W-1:0]  divisor,
  output logic [QW-1:0] quotient,
  output trs_div_stat_t status
);

  localparam int CNT_W = (QW > 1) ? $clog2(QW) : 1;

  logic [W-1:0]     rem;
  logic [W-1:0]     dsh;
  logic [QW-1:0]    q;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;
  logic             fits;

  // The quotient is known to fit QW bits, so the divisor starts shifted up by QW-1.
  assign fits = (rem >= dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dsh <= divisor << (QW - 1);
      q   <= '0;
      cnt <= CNT_W'(QW - 1);
    end else if (busy) begin
      if (fits) begin
        rem <= rem - dsh;
      end
      q   <= {q[QW-2:0], fits};
      dsh <= dsh >> 1;
      cnt <= cnt - 1'b1;
    end
  end

  assign quotient    = q;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// File: rtl/core/thermistor_reading_smoother.sv
// Top level of the two-channel thermistor reading smoother.
// Sequence: a rejected reading goes from the check straight to its result, an accepted
// one passes through window load, offset scaling, numerator, serial divide and tracking first.
// Throughput: one item at a time; the next item is taken while the previous result still
// waits in the output register.
// Reset: synchronous, active high; clears all but the window storage and the item registers.
module thermistor_reading_smoother import trs_pkg::*; #(
  parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  // Configuration writes.
  input  logic              cfg_we,
  input  logic              cfg_addr,
  input  logic [CFG_W-1:0]  cfg_wdata,
  // Input stream.
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [READ_W-1:0] s_tdata,   // reading_centi [15:0]
  input  logic [1:0]        s_tuser,   // sensor_select [0], supply_ok [1]
  // Result stream.
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [15:0]       m_tdata,   // tracked_centi [14:0], zero [15]
  output logic [1:0]        m_tuser    // accepted [0], sensor_error [1]
);

  // Window geometry. Both channel windows share one memory, channel in the top address bit.
  localparam int IDX_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int MEM_D  = 2 * (2 ** IDX_W);
  // The sum of a full window of 14-bit readings.
  localparam int SUM_W  = DATA_W + FILL_W;
  // Divider operands: twice the numerator magnitude plus half the divisor.
  localparam int DIV_W  = SUM_W + QUOT_W;
  localparam int OFF_W  = 8;

  typedef enum logic [7:0] {
    ST_IDLE  = 8'b0000_0001,
    ST_CHECK = 8'b0000_0010,
    ST_LOAD  = 8'b0000_0100,
    ST_SCALE = 8'b0000_1000,
    ST_NUMER = 8'b0001_0000,
    ST_DIV   = 8'b0010_0000,
    ST_TRACK = 8'b0100_0000,
    ST_EMIT  = 8'b1000_0000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [LIMIT_W-1:0] error_limit;
  logic [CFG_W-1:0]   max_valid_temp;

  // Per-channel state, index 0 is the environment sensor and 1 the floor sensor.
  logic [FILL_W-1:0]       fill    [2];
  logic [IDX_W-1:0]        head    [2];
  logic [SUM_W-1:0]        sum     [2];
  logic signed [TRK_W-1:0] tracked [2];
  logic [LIMIT_W-1:0]      rejects [2];
  logic                    error_flag;

  // Item being worked on.
  logic                     ch;
  logic signed [READ_W-1:0] reading;
  logic                     supply;
  logic                     acc;
  logic [OFF_W-1:0]         offset;
  logic                     num_neg;

  // Window memory.
  logic [DATA_W-1:0] win_mem [MEM_D];
  logic [DATA_W-1:0] old_val;

  // Divider hookup.
  logic                div_start;
  logic [DIV_W-1:0]    div_dividend;
  logic [DIV_W-1:0]    div_divisor;
  logic [QUOT_W-1:0]   div_quot;
  trs_div_stat_t       div_stat;

  // Output register.
  logic                    out_valid;
  logic                    out_acc;
  logic signed [TRK_W-1:0] out_tracked;
  logic                    out_err;

  // Combinational helpers.
  logic                    rejected;
  logic [LIMIT_W-1:0]      rej_bumped;
  logic                    full;
  logic [IDX_W-1:0]        wr_idx;
  logic [DATA_W-1:0]       val;
  logic [SUM_W-1:0]        n_ext;
  logic [SUM_W-1:0]        off_scaled;
  logic signed [SUM_W:0]   numer;
  logic [SUM_W-1:0]        numer_mag;
  logic [QUOT_W+6-1:0]     target_mag;
  logic signed [TRK_W-1:0] target;
  logic                    out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !out_valid || m_tready;

  // A reading passes with a good supply and 0 < reading < max_valid_temp.
  assign rejected = !supply || reading[READ_W-1] || (reading == '0) ||
                    ($unsigned(reading) >= {{(READ_W - CFG_W){1'b0}}, max_valid_temp});
  assign rej_bumped = (rejects[ch] == REJECT_MAX) ? REJECT_MAX : rejects[ch] + 1'b1;
  assign val        = reading[DATA_W-1:0];

  // Until the window is full the head stays at zero, so the next free slot is the fill count.
  assign full   = (fill[ch] == FILL_W'(WINDOW_DEPTH));
  assign wr_idx = full ? head[ch] : fill[ch][IDX_W-1:0];

  assign n_ext      = SUM_W'(fill[ch]);
  assign off_scaled = SUM_W'(offset) * n_ext;
  assign numer      = $signed({1'b0, sum[ch]}) - $signed({1'b0, off_scaled});
  assign numer_mag  = numer[SUM_W] ? SUM_W'(-numer) : numer[SUM_W-1:0];

  // Rounded division: (2*|num| + 50n) / (100n), sign restored afterwards.
  assign div_start    = (state == ST_NUMER);
  assign div_dividend = (DIV_W'(numer_mag) << 1) + DIV_W'(n_ext) * DIV_W'(STEP_CENTI);
  assign div_divisor  = DIV_W'(n_ext) * DIV_W'(2 * STEP_CENTI);

  assign target_mag = (QUOT_W + 6)'(div_quot) * (QUOT_W + 6)'(STEP_CENTI);
  assign target     = num_neg ? -$signed(TRK_W'(target_mag)) : $signed(TRK_W'(target_mag));

  trs_divider #(
    .W  (DIV_W),
    .QW (QUOT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quot),
    .status   (div_stat)
  );

  // Configuration writes land whenever the enable is high.
  always_ff @(posedge clk) begin
    if (rst) begin
      error_limit    <= DEF_ERROR_LIMIT;
      max_valid_temp <= DEF_MAX_TEMP;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_addr))
        REG_ERROR_LIMIT:    error_limit    <= cfg_wdata[LIMIT_W-1:0];
        REG_MAX_VALID_TEMP: max_valid_temp <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The oldest entry is read while the checks run, and the new reading is written in the
  // next cycle together with the sum update.
  always_ff @(posedge clk) begin
    if (state == ST_CHECK) begin
      old_val <= win_mem[{ch, head[ch]}];
    end
    if (state == ST_LOAD) begin
      win_mem[{ch, wr_idx}] <= val;
    end
  end

  // Item registers need no reset.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ch      <= s_tuser[0];
      supply  <= s_tuser[1];
      reading <= $signed(s_tdata);
    end
    if (state == ST_SCALE) begin
      if (sum[ch] < SUM_W'(BAND_LOW) * n_ext) begin
        offset <= OFF_W'(OFFSET_LOW);
      end else if (sum[ch] < SUM_W'(BAND_HIGH) * n_ext) begin
        offset <= OFF_W'(OFFSET_MID);
      end else begin
        offset <= OFF_W'(OFFSET_HIGH);
      end
    end
    if (state == ST_NUMER) begin
      num_neg <= numer[SUM_W];
    end
    if (state == ST_EMIT && out_free) begin
      out_acc     <= acc;
      out_tracked <= tracked[ch];
      out_err     <= error_flag;
    end
  end

  // Sequencer and channel state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      error_flag <= 1'b0;
      acc        <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        fill[i]    <= '0;
        head[i]    <= '0;
        sum[i]     <= '0;
        tracked[i] <= '0;
        rejects[i] <= '0;
      end
    end else begin
      // The result register refills when a result is emitted and empties on a transfer.
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (rejected) begin
            acc         <= 1'b0;
            rejects[ch] <= rej_bumped;
            // Both counters count toward the flag, the bumped one at its new value.
            if (rej_bumped >= error_limit || rejects[!ch] >= error_limit) begin
              error_flag <= 1'b1;
            end
            state <= ST_EMIT;
          end else begin
            acc         <= 1'b1;
            rejects[ch] <= '0;
            error_flag  <= 1'b0;
            state       <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (full) begin
            sum[ch]  <= sum[ch] - SUM_W'(old_val) + SUM_W'(val);
            head[ch] <= (head[ch] == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : head[ch] + 1'b1;
          end else begin
            sum[ch]  <= sum[ch] + SUM_W'(val);
            fill[ch] <= fill[ch] + 1'b1;
          end
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_NUMER;
        end
        ST_NUMER: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            state <= ST_TRACK;
          end
        end
        ST_TRACK: begin
          // The first reading in a window sets the value, later ones step toward the target.
          if (fill[ch] == FILL_W'(1)) begin
            tracked[ch] <= target;
          end else if (target > tracked[ch]) begin
            tracked[ch] <= tracked[ch] + TRK_W'(STEP_CENTI);
          end else if (target < tracked[ch]) begin
            tracked[ch] <= tracked[ch] - TRK_W'(STEP_CENTI);
          end
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_tracked};
  assign m_tuser  = {out_err, out_acc};

  // The divider only finishes while the sequencer waits on it.
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == ST_DIV)
    else $error("divider finished outside its wait state");

  // Fill counts never pass the window depth.
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill[0] <= FILL_W'(WINDOW_DEPTH) && fill[1] <= FILL_W'(WINDOW_DEPTH))
    else $error("window fill count beyond depth");

  // An accepted reading always reports a cleared error flag.
  a_accept_clears_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tuser[1])
    else $error("accepted reading reported with error flag set");

  // A new result is only loaded once the previous one has gone out.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT && out_valid && !m_tready |=> state == ST_EMIT)
    else $error("result loaded over a pending one");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for the two-channel thermistor reading smoother.
`timescale 1ns / 1ps

module testbench;
  import trs_pkg::*;

  localparam int WIN = DEF_WINDOW_DEPTH;

  // One expected result: the fields of the result stream.
  typedef struct packed {
    logic             accepted;
    logic [TRK_W-1:0] tracked;
    logic             sensor_error;
  } smoothed_result_t;

  // Scoreboard: tracks both channels the way the smoother should and keeps the
  // results it still owes in arrival order.
  class smoother_scoreboard;
    logic [LIMIT_W-1:0] err_limit;
    logic [CFG_W-1:0]   max_temp;
    logic [DATA_W-1:0]  window [2][WIN];
    int                 fill [2];
    int                 head [2];
    int                 sum [2];
    int                 tracked [2];
    int                 rejects [2];
    logic               err_flag;
    smoothed_result_t   pending_results [$];
    int                 mismatches;

    function new();
      err_limit  = DEF_ERROR_LIMIT;
      max_temp   = DEF_MAX_TEMP;
      err_flag   = 1'b0;
      mismatches = 0;
      for (int c = 0; c < 2; c++) begin
        fill[c]    = 0;
        head[c]    = 0;
        sum[c]     = 0;
        tracked[c] = 0;
        rejects[c] = 0;
      end
    endfunction

    function void write_reg(reg_idx_t idx, logic [CFG_W-1:0] value);
      if (idx == REG_ERROR_LIMIT) begin
        err_limit = value[LIMIT_W-1:0];
      end else begin
        max_temp = value;
      end
    endfunction

    // Nearest integer of num/den with halves away from zero; den is positive.
    function int round_half_away(int num, int den);
      if (num >= 0) begin
        return (2 * num + den) / (2 * den);
      end
      return -((2 * (-num) + den) / (2 * den));
    endfunction

    // Called at the edge where a reading transfer happens.
    function void predict_reading(logic ch, logic signed [READ_W-1:0] rd, logic supply);
      int c;
      int value;
      int n;
      int offset;
      int target;
      smoothed_result_t res;
      c = ch;
      value = rd;
      res.accepted = 1'b0;
      if (!supply || value <= 0 || value >= int'(max_temp)) begin
        if (rejects[c] < int'(REJECT_MAX)) rejects[c]++;
        // Either channel at the limit raises the flag.
        if (rejects[0] >= int'(err_limit) || rejects[1] >= int'(err_limit)) err_flag = 1'b1;
      end else begin
        res.accepted = 1'b1;
        rejects[c] = 0;
        err_flag = 1'b0;
        if (fill[c] >= WIN) begin
          sum[c] = sum[c] - int'(window[c][head[c]]);
          window[c][head[c]] = DATA_W'(value);
          head[c] = (head[c] + 1) % WIN;
        end else begin
          window[c][(head[c] + fill[c]) % WIN] = DATA_W'(value);
          fill[c]++;
        end
        sum[c] = sum[c] + value;
        n = fill[c];
        if (sum[c] < BAND_LOW * n) offset = OFFSET_LOW;
        else if (sum[c] < BAND_HIGH * n) offset = OFFSET_MID;
        else offset = OFFSET_HIGH;
        target = round_half_away(sum[c] - offset * n, STEP_CENTI * n) * STEP_CENTI;
        if (n == 1) tracked[c] = target;
        else if (target > tracked[c]) tracked[c] += STEP_CENTI;
        else if (target < tracked[c]) tracked[c] -= STEP_CENTI;
      end
      res.tracked = TRK_W'(tracked[c]);
      res.sensor_error = err_flag;
      pending_results.insert(pending_results.size(), res);
    endfunction

    function void check_result(logic [15:0] data, logic [1:0] user);
      smoothed_result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result with no reading pending: tdata %h tuser %b", $time, data, user);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      if (user[0] !== want.accepted) begin
        $display("%0t: accepted expected %0b actual %0b", $time, want.accepted, user[0]);
        mismatches++;
      end
      if (data !== {1'b0, want.tracked}) begin
        $display("%0t: tracked_centi expected %0d actual %0d (tdata %h)", $time,
                 $signed(want.tracked), $signed(data[TRK_W-1:0]), data);
        mismatches++;
      end
      if (user[1] !== want.sensor_error) begin
        $display("%0t: sensor_error expected %0b actual %0b", $time,
                 want.sensor_error, user[1]);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic              cfg_addr = REG_ERROR_LIMIT;
  logic [CFG_W-1:0]  cfg_wdata = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [READ_W-1:0] s_tdata = '0;
  logic [1:0]        s_tuser = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [15:0]       m_tdata;
  logic [1:0]        m_tuser;

  smoother_scoreboard model;

  // Random idling on both sides, switched off for one whole phase.
  bit idle_on = 1'b1;
  // Cycles the receiver still holds off; the receiver process counts it down.
  int rx_hold_left = 0;
  // Share of random items that are meant to be rejected, in percent.
  int reject_pct = 20;
  // Per-channel level that the well-formed random readings wander around.
  int level [2] = '{2000, 2000};

  thermistor_reading_smoother DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  always #6 clk = ~clk;

  // Receiver: checks every result transfer, then decides tready for the next
  // cycle. A requested hold-off wins over the random idling.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      model.check_result(m_tdata, m_tuser);
    end
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      m_tready <= 1'b0;
    end else if (idle_on) begin
      m_tready <= ($urandom_range(99) >= 30);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Offers one reading and returns at the edge where its transfer happens.
  // tvalid is left high so that a following item can go out back to back; it
  // is only lowered when a gap is wanted.
  task automatic send_reading(input logic ch, input logic [READ_W-1:0] rd, input logic supply);
    if (idle_on && $urandom_range(99) < 30) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(8, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= rd;
    s_tuser  <= {supply, ch};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    model.predict_reading(ch, rd, supply);
  endtask

  // Stops offering readings and waits until every owed result has arrived.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (model.pending_results.size() != 0) @(posedge clk);
  endtask

  // Writes both registers on back-to-back edges. The spare upper bits of the
  // error limit word are random, since the register keeps only its low bits.
  task automatic write_config(input logic [LIMIT_W-1:0] limit, input logic [CFG_W-1:0] max_t);
    logic [CFG_W-1:0] limit_word;
    limit_word = CFG_W'($urandom);
    limit_word[LIMIT_W-1:0] = limit;
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_ERROR_LIMIT;
    cfg_wdata <= limit_word;
    @(posedge clk);
    model.write_reg(REG_ERROR_LIMIT, limit_word);
    cfg_addr  <= REG_MAX_VALID_TEMP;
    cfg_wdata <= max_t;
    @(posedge clk);
    model.write_reg(REG_MAX_VALID_TEMP, max_t);
    cfg_we <= 1'b0;
  endtask

  // Well-formed readings near a slowly moving level per channel, so the windows
  // fill, wrap and the tracked value settles onto its target. The reject_pct share
  // is bad supply, zero or negative, at or above the limit, or plain noise.
  task automatic random_readings(input int count);
    logic              ch;
    logic              supply;
    logic [READ_W-1:0] rd;
    int                mx;
    int                v;
    for (int i = 0; i < count; i++) begin
      mx = model.max_temp;
      ch = 1'($urandom_range(1));
      supply = 1'b1;
      if (mx > 1 && $urandom_range(99) >= reject_pct) begin
        if ($urandom_range(99) < 5) begin
          // Half of the new levels sit around the offset band edges.
          level[ch] = $urandom_range(1) ? int'($urandom_range(2400, 1800))
                                        : int'($urandom_range(mx - 1, 1));
        end
        v = level[ch] + int'($urandom_range(200)) - 100;
        if (v < 1) v = 1;
        if (v > mx - 1) v = mx - 1;
        rd = READ_W'(v);
      end else begin
        case ($urandom_range(3))
          0: begin
            rd = READ_W'($urandom);
            supply = 1'b0;
          end
          1: rd = $urandom_range(1) ? '0 : (16'h8000 | READ_W'($urandom));
          2: rd = $urandom_range(1) ? READ_W'(mx + int'($urandom_range(50)))
                                    : READ_W'($urandom_range(32767, mx));
          default: begin
            rd = READ_W'($urandom);
            supply = 1'($urandom_range(1));
          end
        endcase
      end
      send_reading(ch, rd, supply);
    end
  endtask

  initial begin
    logic [LIMIT_W-1:0] phase_limit;
    logic [CFG_W-1:0]   phase_max;
    model = new();
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset settings (limit 5, bound 6000).
    send_reading(1'b0, 16'd1, 1'b1);      // smallest good reading, target below zero
    send_reading(1'b0, 16'd5999, 1'b1);   // largest good reading
    send_reading(1'b0, 16'd6000, 1'b1);   // equal to the bound
    send_reading(1'b0, 16'd0, 1'b1);      // zero is rejected
    send_reading(1'b0, 16'h8000, 1'b1);   // most negative reading
    send_reading(1'b0, 16'h7FFF, 1'b1);   // most positive reading
    send_reading(1'b1, 16'd2000, 1'b0);   // good value but the supply check failed
    // Floor rejections: the fifth raises the flag, the counter then climbs to its maximum.
    repeat (4) send_reading(1'b1, 16'hFFFF, 1'b1);
    repeat (2) send_reading(1'b1, 16'hFFFB, 1'b1);
    send_reading(1'b0, 16'd2200, 1'b1);   // accepted: clears the flag
    // One environment rejection raises the flag again through the floor counter.
    send_reading(1'b0, 16'd0, 1'b0);
    send_reading(1'b1, 16'd1899, 1'b1);   // first floor entry sets the tracked value
    // Walk the floor window across the offset bands and past its depth.
    send_reading(1'b1, 16'd1900, 1'b1);
    send_reading(1'b1, 16'd2299, 1'b1);
    send_reading(1'b1, 16'd2300, 1'b1);
    send_reading(1'b1, 16'd4000, 1'b1);
    send_reading(1'b1, 16'd2250, 1'b1);
    send_reading(1'b1, 16'd1850, 1'b1);
    repeat (3) send_reading(1'b1, 16'd2000, 1'b1);
    drain_results();

    // Random phases, each with its own register setting: the reset values, the widest
    // limits, a zero bound that rejects everything together with a zero error limit,
    // and later a bound of one, among other fixed and random settings.
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: begin phase_limit = 3'd5; phase_max = 14'd6000;  end
        1: begin phase_limit = 3'd7; phase_max = 14'h3FFF;  end
        2: begin phase_limit = 3'd0; phase_max = 14'd0;     end
        3: begin phase_limit = 3'd1; phase_max = 14'd10000; end
        4: begin phase_limit = 3'd3; phase_max = 14'd2500;  end
        6: begin phase_limit = LIMIT_W'($urandom_range(7)); phase_max = 14'd1; end
        default: begin
          phase_limit = LIMIT_W'($urandom_range(7));
          phase_max = CFG_W'($urandom_range(16383, 1));
        end
      endcase
      write_config(phase_limit, phase_max);
      reject_pct = (phase % 2 == 0) ? 20 : 55;
      idle_on = (phase != 5);
      // The receiver stops for a long stretch while readings keep coming, so
      // the output register fills and the input side stalls.
      if (phase == 3) rx_hold_left = 400;
      random_readings((phase == 2 || phase == 6) ? 120 : 230);
      drain_results();
    end

    repeat (20) @(posedge clk);
    if (model.mismatches == 0 && model.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #5000000;
    $display("status: fail");
    $finish;
  end

endmodule
